// ----- hdl/wheel_sync_pid_profile_defines.svh -----
// Assertion macros shared by the wheel synchroniser RTL.
`ifndef WHEEL_SYNC_PID_PROFILE_DEFINES_SVH
`define WHEEL_SYNC_PID_PROFILE_DEFINES_SVH
`ifndef SYNTH
`define WSP_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define WSP_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define WSP_ASSERT_IMP(lbl, pre, post, msg)
`define WSP_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ----- hdl/wsp_pkg.sv -----
// Types, codes and defaults shared by the wheel synchroniser modules.
package wsp_pkg;

	localparam int TOTAL_WIDTH_DEF    = 24;
	localparam int INTEGRAL_WIDTH_DEF = 24;

	localparam int ADDR_WIDTH = 5;
	localparam int DATA_WIDTH = 32;

	localparam logic [2:0] REG_GAIN_P     = 3'd0;
	localparam logic [2:0] REG_GAIN_I     = 3'd1;
	localparam logic [2:0] REG_GAIN_D     = 3'd2;
	localparam logic [2:0] REG_SPEED_SLOW = 3'd3;
	localparam logic [2:0] REG_SPEED_MID  = 3'd4;
	localparam logic [2:0] REG_SPEED_FAST = 3'd5;
	localparam logic [2:0] REG_RAMP_SHORT = 3'd6;
	localparam logic [2:0] REG_RAMP_LONG  = 3'd7;

	localparam logic [15:0] GAIN_P_RST     = 16'd819;
	localparam logic [15:0] GAIN_I_RST     = 16'd410;
	localparam logic [15:0] GAIN_D_RST     = 16'd410;
	localparam logic [14:0] SPEED_SLOW_RST = 15'd1638;
	localparam logic [14:0] SPEED_MID_RST  = 15'd4915;
	localparam logic [14:0] SPEED_FAST_RST = 15'd8192;
	localparam logic [15:0] RAMP_SHORT_RST = 16'd700;
	localparam logic [15:0] RAMP_LONG_RST  = 16'd1400;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [1:0] MODE_STRAIGHT = 2'd0;
	localparam logic [1:0] MODE_SPIN_R   = 2'd1;
	localparam logic [1:0] MODE_SPIN_L   = 2'd2;

	localparam logic signed [15:0] DRIVE_MAX = 16'sd16384;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [14:0] speed_slow;
		logic [14:0] speed_mid;
		logic [14:0] speed_fast;
		logic [15:0] ramp_short;
		logic [15:0] ramp_long;
	} wsp_cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [14:0] band;
		logic        zero;
		logic        done;
	} wsp_ctl_t;

endpackage

// ----- hdl/wsp_regs.sv -----
// APB register bank holding the gains, band speeds and ramp lengths.
module wsp_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wsp_pkg::ADDR_WIDTH-1:0]   paddr,
	input  logic [wsp_pkg::DATA_WIDTH-1:0]   pwdata,
	output logic [wsp_pkg::DATA_WIDTH-1:0]   prdata,
	output logic                             pready,
	output wsp_pkg::wsp_cfg_t                cfg
);

	wsp_pkg::wsp_cfg_t cfg_q;
	logic [2:0]        idx;
	logic              wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= wsp_pkg::GAIN_P_RST;
			cfg_q.gain_i     <= wsp_pkg::GAIN_I_RST;
			cfg_q.gain_d     <= wsp_pkg::GAIN_D_RST;
			cfg_q.speed_slow <= wsp_pkg::SPEED_SLOW_RST;
			cfg_q.speed_mid  <= wsp_pkg::SPEED_MID_RST;
			cfg_q.speed_fast <= wsp_pkg::SPEED_FAST_RST;
			cfg_q.ramp_short <= wsp_pkg::RAMP_SHORT_RST;
			cfg_q.ramp_long  <= wsp_pkg::RAMP_LONG_RST;
		end else if (wr) begin
			case (idx)
				wsp_pkg::REG_GAIN_P:     cfg_q.gain_p     <= pwdata[15:0];
				wsp_pkg::REG_GAIN_I:     cfg_q.gain_i     <= pwdata[15:0];
				wsp_pkg::REG_GAIN_D:     cfg_q.gain_d     <= pwdata[15:0];
				wsp_pkg::REG_SPEED_SLOW: cfg_q.speed_slow <= pwdata[14:0];
				wsp_pkg::REG_SPEED_MID:  cfg_q.speed_mid  <= pwdata[14:0];
				wsp_pkg::REG_SPEED_FAST: cfg_q.speed_fast <= pwdata[14:0];
				wsp_pkg::REG_RAMP_SHORT: cfg_q.ramp_short <= pwdata[15:0];
				wsp_pkg::REG_RAMP_LONG:  cfg_q.ramp_long  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			wsp_pkg::REG_GAIN_P:     prdata = 32'(cfg_q.gain_p);
			wsp_pkg::REG_GAIN_I:     prdata = 32'(cfg_q.gain_i);
			wsp_pkg::REG_GAIN_D:     prdata = 32'(cfg_q.gain_d);
			wsp_pkg::REG_SPEED_SLOW: prdata = 32'(cfg_q.speed_slow);
			wsp_pkg::REG_SPEED_MID:  prdata = 32'(cfg_q.speed_mid);
			wsp_pkg::REG_SPEED_FAST: prdata = 32'(cfg_q.speed_fast);
			wsp_pkg::REG_RAMP_SHORT: prdata = 32'(cfg_q.ramp_short);
			wsp_pkg::REG_RAMP_LONG:  prdata = 32'(cfg_q.ramp_long);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ----- hdl/wsp_track.sv -----
// Move state, speed band selection and error terms, registered into stage two.
`include "wheel_sync_pid_profile_defines.svh"
module wsp_track #(
	parameter int TOTAL_WIDTH    = wsp_pkg::TOTAL_WIDTH_DEF,
	parameter int INTEGRAL_WIDTH = wsp_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  wsp_pkg::wsp_cfg_t                cfg,
	input  logic                             cmd_s1,
	input  logic [1:0]                       mode_s1,
	input  logic [23:0]                      target_s1,
	input  logic signed [15:0]               rdelta_s1,
	input  logic signed [15:0]               ldelta_s1,
	output logic signed [16:0]               err_s2,
	output logic signed [INTEGRAL_WIDTH-1:0] sum_s2,
	output logic signed [17:0]               diff_s2,
	output wsp_pkg::wsp_ctl_t                ctl_s2
);

	localparam int TW = TOTAL_WIDTH;
	localparam int IW = INTEGRAL_WIDTH;
	localparam int SW = ((IW > 17) ? IW : 17) + 1;
	localparam int BW = ((TW > 24) ? TW : 24) + 2;
	localparam logic signed [SW-1:0] IMAX = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
	localparam logic signed [SW-1:0] IMIN = ~IMAX;
	localparam logic signed [17:0]   EMAX = 18'sd65535;
	localparam logic signed [17:0]   EMIN = -18'sd65536;

	logic [TW-1:0]          pulse_total_q;
	logic [23:0]            target_q;
	logic [1:0]             mode_q;
	logic [14:0]            band_q;
	logic signed [16:0]     prev_q;
	logic signed [IW-1:0]   err_sum_q;
	logic                   moving_q;

	logic signed [16:0]     cr, cl, e;
	logic signed [17:0]     ediff, dd;
	logic signed [SW-1:0]   sum_ext;
	logic signed [IW-1:0]   sum_new;
	logic signed [TW+1:0]   tsum;
	logic [TW-1:0]          total_new;
	logic signed [BW-1:0]   t, n, rs, rl, n_rs, n_rl;
	logic [14:0]            band_new;
	logic [1:0]             mode_start;
	logic                   reached;

	always_comb begin
		cr = {rdelta_s1[15], rdelta_s1};
		cl = {ldelta_s1[15], ldelta_s1};
		if (mode_q == wsp_pkg::MODE_SPIN_R) begin
			cr = -cr;
		end
		if (mode_q == wsp_pkg::MODE_SPIN_L) begin
			cl = -cl;
		end
		ediff = 18'(cr) - 18'(cl);
		if (ediff > EMAX) begin
			e = EMAX[16:0];
		end else if (ediff < EMIN) begin
			e = EMIN[16:0];
		end else begin
			e = ediff[16:0];
		end
		sum_ext = SW'(err_sum_q) + SW'(e);
		if (sum_ext > IMAX) begin
			sum_new = IMAX[IW-1:0];
		end else if (sum_ext < IMIN) begin
			sum_new = IMIN[IW-1:0];
		end else begin
			sum_new = sum_ext[IW-1:0];
		end
		dd = 18'(e) - 18'(prev_q);

		tsum = $signed({2'b00, pulse_total_q}) + (TW+2)'(cr);
		if (tsum[TW+1]) begin
			total_new = '0;
		end else if (tsum[TW]) begin
			total_new = '1;
		end else begin
			total_new = tsum[TW-1:0];
		end
		reached = BW'(total_new) >= BW'(target_q);

		t    = $signed(BW'(pulse_total_q));
		n    = $signed(BW'(target_q));
		rs   = $signed(BW'(cfg.ramp_short));
		rl   = $signed(BW'(cfg.ramp_long));
		n_rs = n - rs;
		n_rl = n - rl;
		if (t > n_rs) begin
			band_new = cfg.speed_slow;
		end else if (mode_q == wsp_pkg::MODE_STRAIGHT && t > rl && t < n_rl) begin
			band_new = cfg.speed_fast;
		end else if (t > n_rl || t > rs) begin
			band_new = cfg.speed_mid;
		end else begin
			band_new = band_q;
		end

		if (mode_s1 == wsp_pkg::MODE_SPIN_R || mode_s1 == wsp_pkg::MODE_SPIN_L) begin
			mode_start = mode_s1;
		end else begin
			mode_start = wsp_pkg::MODE_STRAIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_total_q <= '0;
			target_q      <= '0;
			mode_q        <= wsp_pkg::MODE_STRAIGHT;
			band_q        <= '0;
			prev_q        <= '0;
			err_sum_q     <= '0;
			moving_q      <= 1'b0;
		end else if (en) begin
			if (cmd_s1 == wsp_pkg::CMD_START) begin
				mode_q        <= mode_start;
				target_q      <= target_s1;
				pulse_total_q <= '0;
				prev_q        <= '0;
				err_sum_q     <= '0;
				band_q        <= cfg.speed_slow;
				moving_q      <= (target_s1 != '0);
			end else if (moving_q) begin
				band_q        <= band_new;
				pulse_total_q <= total_new;
				err_sum_q     <= sum_new;
				prev_q        <= e;
				moving_q      <= !reached;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cmd_s1 == wsp_pkg::CMD_START) begin
				err_s2      <= '0;
				sum_s2      <= '0;
				diff_s2     <= '0;
				ctl_s2.mode <= mode_start;
				ctl_s2.band <= cfg.speed_slow;
				ctl_s2.zero <= (target_s1 == '0);
				ctl_s2.done <= (target_s1 == '0);
			end else if (moving_q) begin
				err_s2      <= e;
				sum_s2      <= sum_new;
				diff_s2     <= dd;
				ctl_s2.mode <= mode_q;
				ctl_s2.band <= band_new;
				ctl_s2.zero <= reached;
				ctl_s2.done <= reached;
			end else begin
				err_s2      <= '0;
				sum_s2      <= '0;
				diff_s2     <= '0;
				ctl_s2.mode <= mode_q;
				ctl_s2.band <= '0;
				ctl_s2.zero <= 1'b1;
				ctl_s2.done <= 1'b0;
			end
		end
	end

	`WSP_ASSERT_IMP(a_moving_below_target, moving_q, BW'(pulse_total_q) < BW'(target_q), "moving with total at or past target")
	`WSP_ASSERT_IMP(a_idle_zero_total_start, en && cmd_s1 == wsp_pkg::CMD_START && target_s1 == '0, ##1 !moving_q, "zero-target start left the move running")

endmodule

// ----- hdl/wsp_pid.sv -----
// PID products in stage three, then correction sum, signs and drive saturation.
module wsp_pid #(
	parameter int INTEGRAL_WIDTH = wsp_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  wsp_pkg::wsp_cfg_t                cfg,
	input  logic signed [16:0]               err_s2,
	input  logic signed [INTEGRAL_WIDTH-1:0] sum_s2,
	input  logic signed [17:0]               diff_s2,
	input  wsp_pkg::wsp_ctl_t                ctl_s2,
	output logic signed [15:0]               right_nx,
	output logic signed [15:0]               left_nx,
	output logic                             done_nx
);

	localparam int IW = INTEGRAL_WIDTH;
	localparam int PW = ((IW > 17) ? IW : 17) + 24;

	logic signed [33:0]    pp_s3;
	logic signed [IW+16:0] pi_s3;
	logic signed [34:0]    pd_s3;
	wsp_pkg::wsp_ctl_t     ctl_s3;

	logic signed [PW-1:0]  corr, left;
	logic signed [16:0]    rgt;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s3  <= $signed({1'b0, cfg.gain_p}) * err_s2;
			pi_s3  <= $signed({1'b0, cfg.gain_i}) * sum_s2;
			pd_s3  <= $signed({1'b0, cfg.gain_d}) * diff_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	always_comb begin
		corr = PW'(pp_s3) + PW'(pi_s3) + PW'(pd_s3);
		left = PW'($signed({1'b0, ctl_s3.band})) + (corr <<< 2);
		if (ctl_s3.mode == wsp_pkg::MODE_SPIN_L) begin
			left = -left;
		end
		if (ctl_s3.mode == wsp_pkg::MODE_SPIN_R) begin
			rgt = -$signed({2'b00, ctl_s3.band});
		end else begin
			rgt = $signed({2'b00, ctl_s3.band});
		end

		if (ctl_s3.zero) begin
			left_nx = '0;
		end else if (left > PW'(wsp_pkg::DRIVE_MAX)) begin
			left_nx = wsp_pkg::DRIVE_MAX;
		end else if (left < -PW'(wsp_pkg::DRIVE_MAX)) begin
			left_nx = -wsp_pkg::DRIVE_MAX;
		end else begin
			left_nx = left[15:0];
		end

		if (ctl_s3.zero) begin
			right_nx = '0;
		end else if (rgt > 17'(wsp_pkg::DRIVE_MAX)) begin
			right_nx = wsp_pkg::DRIVE_MAX;
		end else if (rgt < -17'(wsp_pkg::DRIVE_MAX)) begin
			right_nx = -wsp_pkg::DRIVE_MAX;
		end else begin
			right_nx = rgt[15:0];
		end

		done_nx = ctl_s3.done;
	end

endmodule

// ----- hdl/wheel_sync_pid_profile.sv -----
// Top level of the two-wheel move controller with speed profile and PID sync.
// Throughput: one word per cycle; the input, state, product and result
// registers form a four-stage pipeline that stalls only when the output is held.
// Reset: clears pipeline valids and move state, and loads the register defaults.
`include "wheel_sync_pid_profile_defines.svh"
module wheel_sync_pid_profile #(
	parameter int TOTAL_WIDTH    = wsp_pkg::TOTAL_WIDTH_DEF,
	parameter int INTEGRAL_WIDTH = wsp_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wsp_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [wsp_pkg::DATA_WIDTH-1:0] pwdata,
	output logic [wsp_pkg::DATA_WIDTH-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [1:0]                     move_mode,
	input  logic [23:0]                    target_pulses,
	input  logic signed [15:0]             right_delta,
	input  logic signed [15:0]             left_delta,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             right_drive,
	output logic signed [15:0]             left_drive,
	output logic                           done_res
);

	wsp_pkg::wsp_cfg_t cfg;

	logic                             v_s1, v_s2, v_s3, out_valid_q;
	logic                             mv_s1, mv_s2, mv_s3;
	logic                             free_s1, free_s2, free_s3, load_out, acc;
	logic                             cmd_s1;
	logic [1:0]                       mode_s1;
	logic [23:0]                      target_s1;
	logic signed [15:0]               rdelta_s1, ldelta_s1;
	logic signed [16:0]               err_s2;
	logic signed [INTEGRAL_WIDTH-1:0] sum_s2;
	logic signed [17:0]               diff_s2;
	wsp_pkg::wsp_ctl_t                ctl_s2;
	logic signed [15:0]               right_nx, left_nx;
	logic                             done_nx;
	logic signed [15:0]               right_q, left_q;
	logic                             done_q;

	wsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign load_out = !out_valid_q || out_ready;
	assign mv_s3    = v_s3 && load_out;
	assign free_s3  = !v_s3 || mv_s3;
	assign mv_s2    = v_s2 && free_s3;
	assign free_s2  = !v_s2 || mv_s2;
	assign mv_s1    = v_s1 && free_s2;
	assign free_s1  = !v_s1 || mv_s1;
	assign in_ready = free_s1;
	assign acc      = in_valid && free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= (v_s1 && !mv_s1) || acc;
			v_s2        <= (v_s2 && !mv_s2) || mv_s1;
			v_s3        <= (v_s3 && !mv_s3) || mv_s2;
			out_valid_q <= (out_valid_q && !out_ready) || mv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1    <= cmd;
			mode_s1   <= move_mode;
			target_s1 <= target_pulses;
			rdelta_s1 <= right_delta;
			ldelta_s1 <= left_delta;
		end
		if (mv_s3) begin
			right_q <= right_nx;
			left_q  <= left_nx;
			done_q  <= done_nx;
		end
	end

	wsp_track #(
		.TOTAL_WIDTH    (TOTAL_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (mv_s1),
		.cfg       (cfg),
		.cmd_s1    (cmd_s1),
		.mode_s1   (mode_s1),
		.target_s1 (target_s1),
		.rdelta_s1 (rdelta_s1),
		.ldelta_s1 (ldelta_s1),
		.err_s2    (err_s2),
		.sum_s2    (sum_s2),
		.diff_s2   (diff_s2),
		.ctl_s2    (ctl_s2)
	);

	wsp_pid #(
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_pid (
		.clk      (clk),
		.en       (mv_s2),
		.cfg      (cfg),
		.err_s2   (err_s2),
		.sum_s2   (sum_s2),
		.diff_s2  (diff_s2),
		.ctl_s2   (ctl_s2),
		.right_nx (right_nx),
		.left_nx  (left_nx),
		.done_nx  (done_nx)
	);

	assign out_valid   = out_valid_q;
	assign right_drive = right_q;
	assign left_drive  = left_q;
	assign done_res    = done_q;

	`WSP_ASSERT_IMP(a_done_drives_zero, out_valid && done_res, right_drive == 0 && left_drive == 0, "done word carries a non-zero drive")
	`WSP_ASSERT_IMP(a_drive_range, out_valid, right_drive <= wsp_pkg::DRIVE_MAX && right_drive >= -wsp_pkg::DRIVE_MAX && left_drive <= wsp_pkg::DRIVE_MAX && left_drive >= -wsp_pkg::DRIVE_MAX, "drive outside plus or minus one")
	`WSP_ASSERT_IMP(a_empty_ready, !v_s1, in_ready, "input refused with an empty input stage")
	`WSP_ASSERT_NXT(a_stage_advance, v_s3 && !out_valid, out_valid, "stage three word not moved to the output")

endmodule
